// ===== design/a51_keystream_cipher_defines.svh =====
// ----------------------------------------------------------------------------
// A5/1 keystream cipher assertion macros
// Shared concurrent assertion forms used by the cipher controller.
// ----------------------------------------------------------------------------
`ifndef A51_KEYSTREAM_CIPHER_DEFINES_SVH
`define A51_KEYSTREAM_CIPHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define A51_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define A51_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/a51_pkg.sv =====
// ----------------------------------------------------------------------------
// A5/1 cipher package
// Register widths, sequence lengths and the controller command bundle.
// ----------------------------------------------------------------------------
package a51_pkg;

    localparam int unsigned FIRST_W    = 19;
    localparam int unsigned SECOND_W   = 22;
    localparam int unsigned THIRD_W    = 23;
    localparam int unsigned KEY_W      = 64;
    localparam int unsigned FRAME_W    = 22;
    localparam int unsigned SEED_W     = KEY_W + FRAME_W;

    // Regular clocks during loading (key bits, then frame bits) and mixing clocks.
    localparam int unsigned LOAD_STEPS = SEED_W;
    localparam int unsigned MIX_STEPS  = 100;
    localparam int unsigned CNT_W      = 7;

    localparam int unsigned S_DATA_W   = 24;
    localparam int unsigned M_DATA_W   = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic restart_load; // clear the registers and capture key, frame and data
        logic load_step;    // regular clock of all three registers with the seed bit
        logic maj_step;     // one majority clock
        logic out_load;     // register the result of this majority clock
        logic use_saved;    // combine with the captured data bit, not the input one
    } a51_cmd_t;

endpackage

// ===== design/a51_keystream_cipher.sv =====
// An item without restart registers its result, which is on m_ in the cycle after its transfer.
// Such items go at one per cycle while m_ is not stalled; the single majority clock per bit sets this.
// A restart item clears the registers, then runs the regular load clocks (key bits, then frame
// bits), the mixing clocks and a final clock; the step counter paces the load and mixing clocks.
// Reset (aresetn low, synchronous) clears the registers and the key, so the keystream is
// zero until the first restart; no result is pending after reset.
// ----------------------------------------------------------------------------
// A5/1 keystream cipher top level
// Stream in data bits, stream out data XOR keystream with the keystream bit.
// ----------------------------------------------------------------------------
module a51_keystream_cipher (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration: 64-bit session key, key bit 0 is loaded first.
    input  logic                            cfg_wr_en,
    input  logic [a51_pkg::KEY_W-1:0]       cfg_wr_data,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata from bit 0: data_bit [0], frame_number [22:1], zero padding [23].
    input  logic [a51_pkg::S_DATA_W-1:0]    s_tdata,
    // s_tuser: restart [0].
    input  logic                            s_tuser,
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata from bit 0: out_bit [0], keystream_bit [1], zero padding [7:2].
    output logic [a51_pkg::M_DATA_W-1:0]    m_tdata
);

    // The controller issues one command bundle per cycle. The datapath does the
    // register clocking and holds the result until the output transfer.
    a51_pkg::a51_cmd_t cmd;
    logic              out_bit;
    logic              keystream_bit;

    a51_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_restart (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cmd        (cmd)
    );

    // The frame number is only captured when the transfer carries a restart.
    a51_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_data_bit     (s_tdata[0]),
        .in_frame_number (s_tdata[a51_pkg::FRAME_W:1]),
        .out_bit         (out_bit),
        .keystream_bit   (keystream_bit)
    );

    assign m_tdata = {{(a51_pkg::M_DATA_W - 2){1'b0}}, keystream_bit, out_bit};

endmodule

// ===== design/a51_ctrl.sv =====
// ----------------------------------------------------------------------------
// A5/1 cipher controller
// Sequences restart loading and mixing, and owns both handshakes.
// ----------------------------------------------------------------------------
`include "a51_keystream_cipher_defines.svh"

module a51_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              in_restart,
    output logic              m_tvalid,
    input  logic              m_tready,
    output a51_pkg::a51_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_MIX   = 2'd2;
    localparam logic [1:0] ST_FINAL = 2'd3;

    localparam logic [a51_pkg::CNT_W-1:0] LOAD_LAST = a51_pkg::CNT_W'(a51_pkg::LOAD_STEPS - 1);
    localparam logic [a51_pkg::CNT_W-1:0] MIX_LAST  = a51_pkg::CNT_W'(a51_pkg::MIX_STEPS - 1);

    logic [1:0]                 state_reg, state_next;
    logic [a51_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_free;
    logic                       accept;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_restart) begin
                        cmd.restart_load = 1'b1;
                        cnt_next         = '0;
                        state_next       = ST_LOAD;
                    end else begin
                        cmd.maj_step = 1'b1;
                        cmd.out_load = 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                cmd.load_step = 1'b1;
                if (cnt_reg == LOAD_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_MIX;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MIX: begin
                cmd.maj_step = 1'b1;
                if (cnt_reg == MIX_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_FINAL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    cmd.maj_step  = 1'b1;
                    cmd.out_load  = 1'b1;
                    cmd.use_saved = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A pending result is never overwritten before it is taken.
    `A51_ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.out_load, (!out_valid_reg || m_tready), "result overwritten while stalled")
    // A restart item always enters the loading sequence from its first step.
    `A51_ASSERT_NEXT(a_restart_enters_load, aclk, aresetn, (accept && in_restart), ((state_reg == ST_LOAD) && (cnt_reg == '0)), "restart did not start loading")
    // The last mixing clock is followed by the final output step.
    `A51_ASSERT_NEXT(a_mix_to_final, aclk, aresetn, ((state_reg == ST_MIX) && (cnt_reg == MIX_LAST)), (state_reg == ST_FINAL), "mixing did not end in final step")
    // A non-restart transfer produces a valid result in the next cycle.
    `A51_ASSERT_NEXT(a_fast_result, aclk, aresetn, (accept && !in_restart), (m_tvalid && (state_reg == ST_IDLE)), "plain item gave no result")

endmodule

// ===== design/a51_datapath.sv =====
// ----------------------------------------------------------------------------
// A5/1 cipher datapath
// The three shift registers, key and seed storage, and the result register.
// ----------------------------------------------------------------------------
module a51_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  a51_pkg::a51_cmd_t                   cmd,
    input  logic                                cfg_wr_en,
    input  logic [a51_pkg::KEY_W-1:0]           cfg_wr_data,
    input  logic                                in_data_bit,
    input  logic [a51_pkg::FRAME_W-1:0]         in_frame_number,
    output logic                                out_bit,
    output logic                                keystream_bit
);

    logic [a51_pkg::FIRST_W-1:0]  first_reg, first_next;
    logic [a51_pkg::SECOND_W-1:0] second_reg, second_next;
    logic [a51_pkg::THIRD_W-1:0]  third_reg, third_next;
    logic [a51_pkg::KEY_W-1:0]    key_reg;
    logic [a51_pkg::SEED_W-1:0]   seed_reg;
    logic                         data_reg;
    logic                         out_bit_reg;
    logic                         ks_reg;

    logic inj;
    logic c1, c2, c3, maj;
    logic en1, en2, en3;
    logic fb1, fb2, fb3;
    logic ks, dbit;

    assign inj = cmd.load_step & seed_reg[0];

    assign c1  = first_reg[8];
    assign c2  = second_reg[10];
    assign c3  = third_reg[10];
    assign maj = (c1 & c2) | (c1 & c3) | (c2 & c3);

    assign en1 = cmd.load_step | (cmd.maj_step & (c1 == maj));
    assign en2 = cmd.load_step | (cmd.maj_step & (c2 == maj));
    assign en3 = cmd.load_step | (cmd.maj_step & (c3 == maj));

    assign fb1 = first_reg[18] ^ first_reg[17] ^ first_reg[16] ^ first_reg[13] ^ inj;
    assign fb2 = second_reg[21] ^ second_reg[20] ^ inj;
    assign fb3 = third_reg[22] ^ third_reg[21] ^ third_reg[20] ^ third_reg[7] ^ inj;

    always_comb begin
        priority if (cmd.restart_load) begin
            first_next  = '0;
            second_next = '0;
            third_next  = '0;
        end else begin
            first_next  = en1 ? {first_reg[a51_pkg::FIRST_W-2:0], fb1}   : first_reg;
            second_next = en2 ? {second_reg[a51_pkg::SECOND_W-2:0], fb2} : second_reg;
            third_next  = en3 ? {third_reg[a51_pkg::THIRD_W-2:0], fb3}   : third_reg;
        end
    end

    // Keystream is taken from the top bits after the majority clock.
    assign ks   = first_next[a51_pkg::FIRST_W-1] ^ second_next[a51_pkg::SECOND_W-1]
                ^ third_next[a51_pkg::THIRD_W-1];
    assign dbit = cmd.use_saved ? data_reg : in_data_bit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= '0;
            second_reg <= '0;
            third_reg  <= '0;
            key_reg    <= '0;
        end else begin
            first_reg  <= first_next;
            second_reg <= second_next;
            third_reg  <= third_next;
            if (cfg_wr_en) begin
                key_reg <= cfg_wr_data;
            end
        end
    end

    // Seed holds key bits then frame bits, consumed from bit 0 upward.
    always_ff @(posedge aclk) begin
        if (cmd.restart_load) begin
            seed_reg <= {in_frame_number, key_reg};
            data_reg <= in_data_bit;
        end else if (cmd.load_step) begin
            seed_reg <= {1'b0, seed_reg[a51_pkg::SEED_W-1:1]};
        end
        if (cmd.out_load) begin
            out_bit_reg <= dbit ^ ks;
            ks_reg      <= ks;
        end
    end

    assign out_bit       = out_bit_reg;
    assign keystream_bit = ks_reg;

endmodule
